[rtl/core/i64a_pkg.sv]
// ----------------------------------------------------------------------------
// i64a_pkg
// Shared types and constants for the 64-bit signed ALU with division.
// ----------------------------------------------------------------------------
package i64a_pkg;

	localparam int unsigned W       = 64;
	localparam int unsigned OP_W    = 4;
	// One divider stage per quotient bit.
	localparam int unsigned DIV_STG = W;
	// The multiplier product joins the sideband at this divider stage input.
	localparam int unsigned MUL_JOIN = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_MOD = 4'd4,
		OP_EQ  = 4'd5,
		OP_NE  = 4'd6,
		OP_LT  = 4'd7,
		OP_LE  = 4'd8,
		OP_GT  = 4'd9,
		OP_GE  = 4'd10,
		OP_AND = 4'd11,
		OP_OR  = 4'd12,
		OP_NEG = 4'd13,
		OP_NOT = 4'd14,
		OP_NONE = 4'd15
	} op_t;

	// Per-request data that rides along the divider pipeline.
	typedef struct packed {
		op_t          op;
		logic         neg_q;
		logic         neg_r;
		logic         dz;
		logic [W-1:0] alt;
	} side_t;

endpackage

[rtl/core/i64a_div_stage.sv]
// ----------------------------------------------------------------------------
// i64a_div_stage
// One restoring division step: produces one quotient bit per stage.
// ----------------------------------------------------------------------------
module i64a_div_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [i64a_pkg::W-1:0] in_rem,
	input  logic [i64a_pkg::W-1:0] in_nq,
	input  logic [i64a_pkg::W-1:0] in_den,
	input  i64a_pkg::side_t       in_side,
	output logic                  out_valid,
	output logic [i64a_pkg::W-1:0] out_rem,
	output logic [i64a_pkg::W-1:0] out_nq,
	output logic [i64a_pkg::W-1:0] out_den,
	output i64a_pkg::side_t       out_side
);
	import i64a_pkg::*;

	logic [W-1:0] rem_sh;
	logic [W-1:0] rem_sub;
	logic         take;

	// Shift in the next dividend bit and try to subtract the divisor.
	always_comb begin
		rem_sh  = {in_rem[W-2:0], in_nq[W-1]};
		take    = (rem_sh >= in_den);
		rem_sub = rem_sh - in_den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	// Payload registers: quotient bits fill the dividend word from the bottom.
	always_ff @(posedge clk) begin
		out_rem  <= take ? rem_sub : rem_sh;
		out_nq   <= {in_nq[W-2:0], take};
		out_den  <= in_den;
		out_side <= in_side;
	end

endmodule

[rtl/core/i64a_mul.sv]
// ----------------------------------------------------------------------------
// i64a_mul
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// ----------------------------------------------------------------------------
module i64a_mul (
	input  logic                  clk,
	input  logic [i64a_pkg::W-1:0] a,
	input  logic [i64a_pkg::W-1:0] b,
	output logic [i64a_pkg::W-1:0] prod
);
	import i64a_pkg::*;

	localparam int unsigned H = W / 2;

	logic [W-1:0] p_ll_s1;
	logic [H-1:0] p_lh_s1;
	logic [H-1:0] p_hl_s1;
	logic [W-1:0] p_lh_full;
	logic [W-1:0] p_hl_full;

	// The 32x32 partial products; the high-by-high term falls off the top.
	always_comb begin
		p_lh_full = a[H-1:0] * b[W-1:H];
		p_hl_full = a[W-1:H] * b[H-1:0];
	end

	always_ff @(posedge clk) begin
		p_ll_s1 <= a[H-1:0] * b[H-1:0];
		p_lh_s1 <= p_lh_full[H-1:0];
		p_hl_s1 <= p_hl_full[H-1:0];
	end

	// Add the cross terms into the upper half.
	always_ff @(posedge clk) begin
		prod <= p_ll_s1 + {p_lh_s1 + p_hl_s1, {H{1'b0}}};
	end

endmodule

[rtl/core/int64_alu_trunc_divmod.sv]
// ----------------------------------------------------------------------------
// int64_alu_trunc_divmod
// Pipelined 64-bit signed ALU with truncating divide and remainder.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at each rising edge where start is high and busy is
// low. busy is always low: the pipeline takes a new request every cycle.
// operation selects the function, left_value and right_value are operands.
// Every request gives exactly one result, shown for one cycle with done
// high, on result_value and divide_by_zero. The receiver cannot hold results
// off, and none is needed since the pipeline never stalls.
// Every operation takes the same path: one input register, 64 divider
// stages (one quotient bit each, set by the restoring subtract of 64 bits),
// and one output register that applies signs and selects the result.
// Multiply uses a two-stage partial-product unit whose product joins the
// pipeline alongside the divider. Throughput is one request per cycle.
// Division or remainder by zero gives 0 with divide_by_zero set.
// Reset clears all valid bits; results in flight are dropped.
// ----------------------------------------------------------------------------
module int64_alu_trunc_divmod (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [i64a_pkg::OP_W-1:0] operation,
	input  logic signed [i64a_pkg::W-1:0] left_value,
	input  logic signed [i64a_pkg::W-1:0] right_value,
	output logic                   done,
	output logic signed [i64a_pkg::W-1:0] result_value,
	output logic                   divide_by_zero
);
	import i64a_pkg::*;

	logic         acc;
	logic [W-1:0] lmag;
	logic [W-1:0] rmag;
	logic [W-1:0] simple;
	logic         lz;
	logic         lt;
	logic         gt;
	logic         eq;
	side_t        side_in;

	logic         valid_s1;
	logic [W-1:0] l_s1;
	logic [W-1:0] r_s1;
	logic [W-1:0] lmag_s1;
	logic [W-1:0] rmag_s1;
	side_t        side_s1;
	logic [W-1:0] mul_prod;

	logic         v_st  [DIV_STG+1];
	logic [W-1:0] rem_st[DIV_STG+1];
	logic [W-1:0] nq_st [DIV_STG+1];
	logic [W-1:0] den_st[DIV_STG+1];
	side_t        sd_st [DIV_STG+1];

	logic [W-1:0] fin_val;
	side_t        fin_sd;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	// Operand magnitudes and all results that need no multiply or divide.
	always_comb begin
		lmag = left_value[W-1]  ? (~left_value + 1'b1)  : left_value;
		rmag = right_value[W-1] ? (~right_value + 1'b1) : right_value;
		lz   = (left_value == '0);
		eq   = (left_value == right_value);
		lt   = (left_value < right_value);
		gt   = (right_value < left_value);
		case (op_t'(operation))
			OP_ADD:  simple = left_value + right_value;
			OP_SUB:  simple = left_value - right_value;
			OP_EQ:   simple = {{(W-1){1'b0}}, eq};
			OP_NE:   simple = {{(W-1){1'b0}}, !eq};
			OP_LT:   simple = {{(W-1){1'b0}}, lt};
			OP_LE:   simple = {{(W-1){1'b0}}, !gt};
			OP_GT:   simple = {{(W-1){1'b0}}, gt};
			OP_GE:   simple = {{(W-1){1'b0}}, !lt};
			OP_AND:  simple = lz ? '0 : right_value;
			OP_OR:   simple = lz ? right_value : left_value;
			OP_NEG:  simple = ~left_value + 1'b1;
			OP_NOT:  simple = {{(W-1){1'b0}}, lz};
			default: simple = '0;
		endcase
		side_in.op    = op_t'(operation);
		side_in.neg_q = left_value[W-1] ^ right_value[W-1];
		side_in.neg_r = left_value[W-1];
		side_in.dz    = (right_value == '0) &&
			(op_t'(operation) == OP_DIV || op_t'(operation) == OP_MOD);
		side_in.alt   = simple;
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		l_s1    <= left_value;
		r_s1    <= right_value;
		lmag_s1 <= lmag;
		rmag_s1 <= rmag;
		side_s1 <= side_in;
	end

	i64a_mul u_mul (
		.clk  (clk),
		.a    (l_s1),
		.b    (r_s1),
		.prod (mul_prod)
	);

	// Divider pipeline head.
	assign v_st[0]   = valid_s1;
	assign rem_st[0] = '0;
	assign nq_st[0]  = lmag_s1;
	assign den_st[0] = rmag_s1;
	assign sd_st[0]  = side_s1;

	for (genvar k = 0; k < DIV_STG; k++) begin : g_div
		side_t sd_in;

		// The product lines up with the sideband at one stage boundary.
		if (k == MUL_JOIN) begin : g_join
			always_comb begin
				sd_in = sd_st[k];
				if (sd_st[k].op == OP_MUL) begin
					sd_in.alt = mul_prod;
				end
			end
		end else begin : g_pass
			assign sd_in = sd_st[k];
		end

		i64a_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_st[k]),
			.in_rem    (rem_st[k]),
			.in_nq     (nq_st[k]),
			.in_den    (den_st[k]),
			.in_side   (sd_in),
			.out_valid (v_st[k+1]),
			.out_rem   (rem_st[k+1]),
			.out_nq    (nq_st[k+1]),
			.out_den   (den_st[k+1]),
			.out_side  (sd_st[k+1])
		);
	end

	// Apply signs to quotient or remainder and pick the final result.
	always_comb begin
		fin_sd = sd_st[DIV_STG];
		case (fin_sd.op)
			OP_DIV:  fin_val = fin_sd.neg_q ? (~nq_st[DIV_STG] + 1'b1) : nq_st[DIV_STG];
			OP_MOD:  fin_val = fin_sd.neg_r ? (~rem_st[DIV_STG] + 1'b1) : rem_st[DIV_STG];
			default: fin_val = fin_sd.alt;
		endcase
		if (fin_sd.dz) begin
			fin_val = '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_st[DIV_STG];
		end
	end

	always_ff @(posedge clk) begin
		result_value   <= fin_val;
		divide_by_zero <= fin_sd.dz;
	end

	// A zero-divisor result always carries a zero value.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_by_zero |-> result_value == '0)
		else $error("divide by zero result is not zero");

	// A result strobe follows a valid last divider stage.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		v_st[DIV_STG] |=> done)
		else $error("result strobe lost");

	// The zero-divisor flag is only raised for divide or remainder.
	a_dz_op: assert property (@(posedge clk) disable iff (!arst_n)
		v_st[DIV_STG] && sd_st[DIV_STG].dz |->
			(sd_st[DIV_STG].op == OP_DIV || sd_st[DIV_STG].op == OP_MOD))
		else $error("zero-divisor flag on wrong operation");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 64-bit signed ALU: a directed table of edge
// cases followed by random requests, every result checked against the table or a predictor.
// ----------------------------------------------------------------------------
module tb;
	import i64a_pkg::*;

	localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_V = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG1  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int N_RANDOM  = 1330;
	localparam int WDOG_MAX  = 5000;
	localparam int LATENCY   = 66;

	typedef struct {
		logic [63:0] value;
		logic        dz;
	} alu_out_t;

	typedef struct {
		op_t         op;
		logic [63:0] a;
		logic [63:0] b;
		logic        known;
		logic [63:0] want;
		logic        want_dz;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [OP_W-1:0] operation = '0;
	logic signed [63:0] left_value = '0;
	logic signed [63:0] right_value = '0;
	logic done;
	logic signed [63:0] result_value;
	logic divide_by_zero;

	alu_out_t pending_results[$];
	int errors = 0;
	int idle_cycles = 0;

	int64_alu_trunc_divmod DUT (.*);

	always #5 clk = ~clk;

	// Absolute value of a two's complement pattern.
	function automatic logic [63:0] mag(logic [63:0] x);
		return x[63] ? -x : x;
	endfunction

	// Predicts the result of one request.
	function automatic alu_out_t alu_predict(op_t op, logic [63:0] a, logic [63:0] b);
		alu_out_t r;
		logic [63:0] q;
		r.value = '0;
		r.dz = 1'b0;
		case (op)
			OP_ADD: r.value = a + b;
			OP_SUB: r.value = a - b;
			OP_MUL: r.value = a * b;
			OP_DIV, OP_MOD: begin
				if (b == 0) begin
					r.dz = 1'b1;
				end else if (op == OP_DIV) begin
					q = mag(a) / mag(b);
					r.value = (a[63] ^ b[63]) ? -q : q;
				end else begin
					q = mag(a) % mag(b);
					r.value = a[63] ? -q : q;
				end
			end
			OP_EQ:  r.value = 64'(a == b);
			OP_NE:  r.value = 64'(a != b);
			OP_LT:  r.value = 64'($signed(a) < $signed(b));
			OP_LE:  r.value = 64'($signed(a) <= $signed(b));
			OP_GT:  r.value = 64'($signed(a) > $signed(b));
			OP_GE:  r.value = 64'($signed(a) >= $signed(b));
			OP_AND: r.value = (a == 0) ? 64'd0 : b;
			OP_OR:  r.value = (a != 0) ? a : b;
			OP_NEG: r.value = -a;
			OP_NOT: r.value = 64'(a == 0);
			default: r.value = '0;
		endcase
		return r;
	endfunction

	// Random operand biased toward extremes and small values.
	function automatic logic [63:0] rand_operand();
		case ($urandom_range(9))
			0: return MIN_V;
			1: return MAX_V;
			2: return NEG1;
			3: return 64'd0;
			4: return 64'($signed($urandom_range(20)) - 10);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Gap before the next request: mostly none or short, a few long.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(9) < 6) ? 0 : ($urandom_range(19) == 0 ?
			$urandom_range(80, 20) : $urandom_range(3, 1));
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Drives one request and waits for it to be taken.
	task automatic issue(op_t op, logic [63:0] a, logic [63:0] b, alu_out_t expv);
		bit taken;
		start <= 1'b1;
		operation <= op;
		left_value <= a;
		right_value <= b;
		// busy is stable from the falling edge up to the next rising edge.
		forever begin
			#0 taken = !busy;
			@(posedge clk);
			if (taken) break;
			@(negedge clk);
		end
		pending_results = {pending_results, expv};
		@(negedge clk);
	endtask

	// Result checker.
	always @(posedge clk) begin
		alu_out_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result value=%h dz=%b", $time,
					result_value, divide_by_zero);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (result_value !== e.value) begin
					$display("%0t: result_value expected %h actual %h", $time,
						e.value, result_value);
					errors++;
				end
				if (divide_by_zero !== e.dz) begin
					$display("%0t: divide_by_zero expected %b actual %b", $time,
						e.dz, divide_by_zero);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles where no request or result moves.
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		alu_out_t e;
		rows = '{
			'{OP_ADD, MAX_V, 64'd1, 1, MIN_V, 0},
			'{OP_SUB, MIN_V, 64'd1, 1, MAX_V, 0},
			'{OP_MUL, MIN_V, NEG1, 1, MIN_V, 0},
			'{OP_MUL, MAX_V, MAX_V, 0, 0, 0},
			'{OP_DIV, 64'd7, 64'd0, 1, 64'd0, 1},
			'{OP_MOD, MIN_V, 64'd0, 1, 64'd0, 1},
			'{OP_DIV, MIN_V, NEG1, 1, MIN_V, 0},
			'{OP_MOD, MIN_V, NEG1, 1, 64'd0, 0},
			'{OP_DIV, -64'd7, 64'd2, 1, -64'd3, 0},
			'{OP_MOD, -64'd7, 64'd2, 1, NEG1, 0},
			'{OP_MOD, 64'd7, -64'd2, 1, 64'd1, 0},
			'{OP_DIV, MAX_V, MIN_V, 1, 64'd0, 0},
			'{OP_EQ, MIN_V, MIN_V, 1, 64'd1, 0},
			'{OP_NE, MIN_V, MAX_V, 1, 64'd1, 0},
			'{OP_LT, MIN_V, MAX_V, 1, 64'd1, 0},
			'{OP_LE, MAX_V, MIN_V, 1, 64'd0, 0},
			'{OP_GT, 64'd0, NEG1, 1, 64'd1, 0},
			'{OP_GE, NEG1, NEG1, 1, 64'd1, 0},
			'{OP_AND, 64'd0, MAX_V, 1, 64'd0, 0},
			'{OP_AND, NEG1, MIN_V, 1, MIN_V, 0},
			'{OP_OR, 64'd0, MIN_V, 1, MIN_V, 0},
			'{OP_OR, MAX_V, 64'd3, 1, MAX_V, 0},
			'{OP_NEG, MIN_V, MAX_V, 1, MIN_V, 0},
			'{OP_NOT, 64'd0, NEG1, 1, 64'd1, 0},
			'{OP_NONE, NEG1, NEG1, 1, 64'd0, 0}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table.
		foreach (rows[i]) begin
			rw = rows[i];
			if (rw.known) begin
				e.value = rw.want;
				e.dz = rw.want_dz;
			end else begin
				e = alu_predict(rw.op, rw.a, rw.b);
			end
			issue(rw.op, rw.a, rw.b, e);
		end

		// Random requests, every code including the unused one.
		for (int i = 0; i < N_RANDOM; i++) begin
			op_t op;
			logic [63:0] a, b;
			idle_gap();
			op = op_t'($urandom_range(15));
			a = rand_operand();
			b = rand_operand();
			issue(op, a, b, alu_predict(op, a, b));
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
